// ===== rtl/polar_envelope_phase_shaper_core_defines.svh =====
// Assertion macros shared by the checker.
`ifndef POLAR_ENVELOPE_PHASE_SHAPER_CORE_DEFINES_SVH
`define POLAR_ENVELOPE_PHASE_SHAPER_CORE_DEFINES_SVH

// Clocked on clk_i, idle while rst_ni is low.
`define PEPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("peps: property violated");

// Once cond is seen, sig holds its value into the next cycle.
`define PEPS_ASSERT_STABLE(lbl, cond, sig) \
  `PEPS_ASSERT(lbl, (cond) |=> $stable(sig))

`endif

// ===== rtl/peps_pkg.sv =====
package peps_pkg;

  localparam int unsigned ADDR_W = 5;

  localparam logic [2:0] REG_DEPTH   = 3'd0;
  localparam logic [2:0] REG_ALPHA   = 3'd1;
  localparam logic [2:0] REG_CLOSE   = 3'd2;
  localparam logic [2:0] REG_OPEN    = 3'd3;
  localparam logic [2:0] REG_HOLDOFF = 3'd4;
  localparam logic [2:0] REG_GAIN    = 3'd5;

  localparam logic [6:0]  RST_DEPTH   = 7'd75;
  localparam logic [9:0]  RST_ALPHA   = 10'd154;
  localparam logic [15:0] RST_CLOSE   = 16'd983;
  localparam logic [15:0] RST_OPEN    = 16'd2621;
  localparam logic [14:0] RST_HOLDOFF = 15'd1600;
  localparam logic [31:0] RST_GAIN    = 32'd65536;

  localparam logic [15:0] RST_HELD = 16'd16384;
  localparam logic [25:0] RST_ACC  = 26'd16777216;

  // target = floor(env * depth * 256 / 25), via reciprocal and one correction
  localparam logic [31:0] TGT_RECIP = 32'd2748779069;
  localparam logic [31:0] TGT_DIV   = 32'd25;
  localparam logic [26:0] TGT_MAX   = 27'd67107840;

  // remainder of |slope| / steps, steps at most 32
  localparam int unsigned REM_W = 5;

  localparam int unsigned FIFO_DEPTH = 2;

  typedef struct packed {
    logic [6:0]  depth_percent;
    logic [9:0]  smooth_alpha;
    logic [15:0] gate_close_level;
    logic [15:0] gate_open_level;
    logic [14:0] holdoff_samples;
    logic [31:0] phase_gain;
  } peps_cfg_t;

  typedef struct packed {
    logic [15:0]      base;
    logic             neg;
    logic [15:0]      quo;
    logic [REM_W-1:0] rem;
    logic [23:0]      step;
    logic             gate_open;
    logic             gate_changed;
  } peps_run_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL_A,
    F_MUL_B,
    F_TGT,
    F_MUL_S,
    F_SUM,
    F_DIV,
    F_PUSH
  } peps_fstate_e;

endpackage

// ===== rtl/peps_fifo.sv =====
module peps_fifo
  import peps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  peps_run_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output peps_run_t pop_data_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  peps_run_t mem_q [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o     = (count_q == (PtrW+1)'(FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/peps_front.sv =====
module peps_front
  import peps_pkg::*;
#(
  parameter int unsigned INTERP_STEPS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  peps_cfg_t          cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        envelope_i,
  input  logic signed [19:0] phase_delta_i,
  output logic               push_o,
  output peps_run_t          run_o,
  input  logic               full_i
);

  localparam logic [31:0] StepRecip = 32'((64'd1 << 32) / INTERP_STEPS);

  peps_fstate_e state_q, state_d;

  logic [15:0]        held_q;
  logic [25:0]        acc_q;
  logic signed [32:0] frac_q;
  logic               gate_open_q;
  logic [14:0]        quiet_q;

  logic [15:0]        env_q;
  logic signed [19:0] ph_q;
  logic [22:0]        xprod_q;
  logic signed [52:0] pprod_q;
  logic [26:0]        tq0_q;
  logic [25:0]        target_q;
  logic [35:0]        p1_q;
  logic [36:0]        p2_q;
  logic [15:0]        m_q;
  logic               neg_q;
  logic [15:0]        base_q;
  logic [15:0]        mq0_q;
  logic [23:0]        step_q;
  logic               chg_q;

  // phase accumulator
  logic signed [32:0] gain_s;
  logic signed [52:0] pprod_d;
  logic signed [53:0] pacc;
  logic               pfix;
  logic [21:0]        step22;
  logic [62:0]        tprod;

  // gate
  logic        gate_open_d;
  logic [14:0] quiet_d;
  logic [14:0] quiet_inc;

  // target correction
  logic [31:0] tgt_y;
  logic [31:0] tgt_r;
  logic [26:0] tgt_q;

  // smoothing
  logic [37:0]        ssum;
  logic signed [16:0] slope;

  // slope split into quotient and remainder by the step count
  logic [47:0]      mprod;
  logic [21:0]      mrem;
  logic [15:0]      quo;
  logic [REM_W-1:0] rem;

  assign gain_s  = $signed({1'b0, cfg_i.phase_gain});
  assign pprod_d = gain_s * ph_q;
  assign pacc    = pprod_q + frac_q;
  assign pfix    = pacc[53] && (pacc[31:0] != 32'd0);
  assign step22  = pacc[53:32] + {21'd0, pfix};

  assign tprod = {32'd0, xprod_q, 8'd0} * {31'd0, TGT_RECIP};

  assign quiet_inc = quiet_q + 15'd1;

  always_comb begin
    gate_open_d = gate_open_q;
    quiet_d     = quiet_q;
    if (gate_open_q) begin
      if (env_q < cfg_i.gate_close_level) begin
        quiet_d = quiet_inc;
        if (quiet_inc >= cfg_i.holdoff_samples) begin
          gate_open_d = 1'b0;
          quiet_d     = '0;
        end
      end else begin
        quiet_d = '0;
      end
    end else if (env_q >= cfg_i.gate_open_level) begin
      gate_open_d = 1'b1;
      quiet_d     = '0;
    end
  end

  always_comb begin
    tgt_y = {1'b0, xprod_q, 8'd0};
    tgt_r = tgt_y - ({5'd0, tq0_q} * TGT_DIV);
    tgt_q = (tgt_r >= TGT_DIV) ? tq0_q + 27'd1 : tq0_q;
  end

  assign ssum  = {2'b00, p1_q} + {1'b0, p2_q};
  assign slope = $signed({1'b0, ssum[35:20]}) - $signed({1'b0, held_q});

  assign mprod = {32'd0, m_q} * {16'd0, StepRecip};

  always_comb begin
    mrem = {6'd0, m_q} - ({6'd0, mq0_q} * 22'(INTERP_STEPS));
    if (mrem >= 22'(INTERP_STEPS)) begin
      quo = mq0_q + 16'd1;
      rem = REM_W'(mrem - 22'(INTERP_STEPS));
    end else begin
      quo = mq0_q;
      rem = REM_W'(mrem);
    end
  end

  always_comb begin
    run_o.base         = base_q;
    run_o.neg          = neg_q;
    run_o.quo          = quo;
    run_o.rem          = rem;
    run_o.step         = step_q;
    run_o.gate_open    = gate_open_q;
    run_o.gate_changed = chg_q;
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    push_o     = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = F_MUL_A;
        end
      end
      F_MUL_A: state_d = F_MUL_B;
      F_MUL_B: state_d = F_TGT;
      F_TGT:   state_d = F_MUL_S;
      F_MUL_S: state_d = F_SUM;
      F_SUM:   state_d = F_DIV;
      F_DIV:   state_d = F_PUSH;
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      held_q      <= RST_HELD;
      acc_q       <= RST_ACC;
      frac_q      <= '0;
      gate_open_q <= 1'b1;
      quiet_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == F_MUL_B) begin
        frac_q      <= {pfix, pacc[31:0]};
        gate_open_q <= gate_open_d;
        quiet_q     <= quiet_d;
      end
      if (state_q == F_SUM) begin
        acc_q  <= ssum[35:10];
        held_q <= ssum[35:20];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        env_q <= envelope_i;
        ph_q  <= phase_delta_i;
      end
      F_MUL_A: begin
        xprod_q <= {7'd0, env_q} * {16'd0, cfg_i.depth_percent};
        pprod_q <= pprod_d;
      end
      F_MUL_B: begin
        tq0_q  <= tprod[62:36];
        step_q <= {{2{step22[21]}}, step22};
        chg_q  <= (gate_open_d != gate_open_q);
      end
      F_TGT: begin
        target_q <= (tgt_q > TGT_MAX) ? TGT_MAX[25:0] : tgt_q[25:0];
      end
      F_MUL_S: begin
        p1_q <= {10'd0, acc_q} * {26'd0, cfg_i.smooth_alpha};
        p2_q <= {11'd0, target_q} * (37'd1024 - {27'd0, cfg_i.smooth_alpha});
      end
      F_SUM: begin
        base_q <= held_q;
        neg_q  <= slope[16];
        m_q    <= slope[16] ? 16'(-slope) : slope[15:0];
      end
      F_DIV: begin
        mq0_q <= mprod[47:32];
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/peps_back.sv =====
module peps_back
  import peps_pkg::*;
#(
  parameter int unsigned INTERP_STEPS = 12,
  parameter int unsigned PWM_BITS     = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fifo_empty_i,
  input  peps_run_t           run_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PWM_BITS-1:0] pwm_level_o,
  output logic [23:0]         phase_step_o,
  output logic                gate_is_open_o,
  output logic                gate_changed_o,
  output logic                last_of_run_o
);

  localparam int unsigned KW      = $clog2(INTERP_STEPS + 1);
  localparam int unsigned SdShift = 16 - PWM_BITS;
  localparam logic signed [18:0] SdHalf = 19'(2 ** (SdShift - 1));
  localparam logic signed [18:0] PwmMax = 19'(2 ** PWM_BITS - 1);

  // interpolation sequencer
  logic             gen_busy_q;
  logic [KW-1:0]    k_q;
  logic [15:0]      base_q;
  logic             neg_q;
  logic [15:0]      qm_q;
  logic [REM_W-1:0] rm_q;
  logic [16:0]      q_q;
  logic [REM_W-1:0] r_q;
  logic [23:0]      step_q;
  logic             gopen_q;

  // level stage
  logic        lv_valid_q;
  logic [15:0] lv_q;
  logic        lv_last_q;
  logic        lv_chg_q;
  logic [23:0] lv_step_q;
  logic        lv_gopen_q;

  // sigma-delta and output
  logic signed [7:0]   res_q;
  logic                out_valid_q;
  logic [PWM_BITS-1:0] out_pwm_q;
  logic [23:0]         out_step_q;
  logic                out_gopen_q;
  logic                out_chg_q;
  logic                out_last_q;

  logic lv_free, start, emit, sd_take, k_last;

  logic [REM_W:0]     rsum;
  logic [16:0]        q_adv;
  logic [REM_W-1:0]   r_adv;
  logic signed [18:0] lvl_s;
  logic [15:0]        lvl;

  logic signed [18:0] t, u, ushr, v, r;
  logic signed [7:0]  res_d;

  assign sd_take = lv_valid_q && (!out_valid_q || !out_stall_i);
  assign lv_free = !lv_valid_q || sd_take;
  assign start   = !gen_busy_q && !fifo_empty_i && lv_free;
  assign emit    = gen_busy_q && lv_free;
  assign pop_o   = start;
  assign k_last  = (k_q == KW'(INTERP_STEPS));

  always_comb begin
    rsum = {1'b0, r_q} + {1'b0, rm_q};
    if (rsum >= (REM_W+1)'(INTERP_STEPS)) begin
      r_adv = REM_W'(rsum - (REM_W+1)'(INTERP_STEPS));
      q_adv = q_q + {1'b0, qm_q} + 17'd1;
    end else begin
      r_adv = REM_W'(rsum);
      q_adv = q_q + {1'b0, qm_q};
    end
  end

  always_comb begin
    if (neg_q) begin
      lvl_s = $signed({3'b000, base_q}) - $signed({2'b00, q_q});
    end else begin
      lvl_s = $signed({3'b000, base_q}) + $signed({2'b00, q_q});
    end
    if (lvl_s < 0) begin
      lvl = '0;
    end else if (lvl_s > 19'sd65535) begin
      lvl = 16'hFFFF;
    end else begin
      lvl = lvl_s[15:0];
    end
  end

  always_comb begin
    t    = $signed({3'b000, lv_q}) + res_q;
    u    = t + SdHalf;
    ushr = u >>> SdShift;
    if (u < 0) begin
      v = '0;
    end else if (ushr > PwmMax) begin
      v = PwmMax;
    end else begin
      v = ushr;
    end
    r = t - (v <<< SdShift);
    if (r > 19'sd127) begin
      res_d = 8'sd127;
    end else if (r < -19'sd128) begin
      res_d = -8'sd128;
    end else begin
      res_d = r[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_busy_q  <= 1'b0;
      k_q         <= '0;
      lv_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (start) begin
        gen_busy_q <= 1'b1;
        k_q        <= KW'(1);
      end else if (emit) begin
        k_q <= k_q + 1'b1;
        if (k_last) begin
          gen_busy_q <= 1'b0;
        end
      end
      if (start || emit) begin
        lv_valid_q <= 1'b1;
      end else if (sd_take) begin
        lv_valid_q <= 1'b0;
      end
      if (sd_take) begin
        out_valid_q <= 1'b1;
        res_q       <= res_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      base_q     <= run_i.base;
      neg_q      <= run_i.neg;
      qm_q       <= run_i.quo;
      rm_q       <= run_i.rem;
      q_q        <= {1'b0, run_i.quo};
      r_q        <= run_i.rem;
      step_q     <= run_i.step;
      gopen_q    <= run_i.gate_open;
      lv_q       <= run_i.base;
      lv_last_q  <= 1'b0;
      lv_chg_q   <= run_i.gate_changed;
      lv_step_q  <= run_i.step;
      lv_gopen_q <= run_i.gate_open;
    end else if (emit) begin
      q_q        <= q_adv;
      r_q        <= r_adv;
      lv_q       <= lvl;
      lv_last_q  <= k_last;
      lv_chg_q   <= 1'b0;
      lv_step_q  <= step_q;
      lv_gopen_q <= gopen_q;
    end
    if (sd_take) begin
      out_pwm_q   <= v[PWM_BITS-1:0];
      out_step_q  <= lv_step_q;
      out_gopen_q <= lv_gopen_q;
      out_chg_q   <= lv_chg_q;
      out_last_q  <= lv_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pwm_level_o    = out_pwm_q;
  assign phase_step_o   = out_step_q;
  assign gate_is_open_o = out_gopen_q;
  assign gate_changed_o = out_chg_q;
  assign last_of_run_o  = out_last_q;

endmodule

// ===== rtl/polar_envelope_phase_shaper_core.sv =====
// A sample's first word passes the front sequencer, run FIFO, level stage and output
// register. A sample yields INTERP_STEPS+1 words, one per cycle while out_stall_i
// is low. The front sequencer takes a sample in F_IDLE, waits for FIFO space, pushes
// its run and can take the next sample while the back sequencer still emits words.
// Reset (async, active low) loads register defaults, held level 16384, open gate,
// zero residue and fraction; the core is ready as soon as reset is released.
module polar_envelope_phase_shaper_core
  import peps_pkg::*;
#(
  parameter int unsigned INTERP_STEPS = 12,
  parameter int unsigned PWM_BITS     = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         envelope_i,
  input  logic signed [19:0]  phase_delta_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PWM_BITS-1:0] pwm_level_o,
  output logic signed [23:0]  phase_step_o,
  output logic                gate_is_open_o,
  output logic                gate_changed_o,
  output logic                last_of_run_o
);

  peps_cfg_t cfg_q;
  logic      cfg_wr;
  logic      push, full, pop, empty;
  peps_run_t push_run, pop_run;
  logic [23:0] step_bits;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_percent    <= RST_DEPTH;
      cfg_q.smooth_alpha     <= RST_ALPHA;
      cfg_q.gate_close_level <= RST_CLOSE;
      cfg_q.gate_open_level  <= RST_OPEN;
      cfg_q.holdoff_samples  <= RST_HOLDOFF;
      cfg_q.phase_gain       <= RST_GAIN;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_DEPTH:   cfg_q.depth_percent    <= pwdata[6:0];
        REG_ALPHA:   cfg_q.smooth_alpha     <= pwdata[9:0];
        REG_CLOSE:   cfg_q.gate_close_level <= pwdata[15:0];
        REG_OPEN:    cfg_q.gate_open_level  <= pwdata[15:0];
        REG_HOLDOFF: cfg_q.holdoff_samples  <= pwdata[14:0];
        REG_GAIN:    cfg_q.phase_gain       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_DEPTH:   prdata = {25'd0, cfg_q.depth_percent};
      REG_ALPHA:   prdata = {22'd0, cfg_q.smooth_alpha};
      REG_CLOSE:   prdata = {16'd0, cfg_q.gate_close_level};
      REG_OPEN:    prdata = {16'd0, cfg_q.gate_open_level};
      REG_HOLDOFF: prdata = {17'd0, cfg_q.holdoff_samples};
      REG_GAIN:    prdata = cfg_q.phase_gain;
      default:     prdata = '0;
    endcase
  end

  peps_front #(
    .INTERP_STEPS(INTERP_STEPS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .envelope_i   (envelope_i),
    .phase_delta_i(phase_delta_i),
    .push_o       (push),
    .run_o        (push_run),
    .full_i       (full)
  );

  peps_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_run),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_run),
    .empty_o    (empty)
  );

  peps_back #(
    .INTERP_STEPS(INTERP_STEPS),
    .PWM_BITS    (PWM_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_empty_i  (empty),
    .run_i         (pop_run),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pwm_level_o   (pwm_level_o),
    .phase_step_o  (step_bits),
    .gate_is_open_o(gate_is_open_o),
    .gate_changed_o(gate_changed_o),
    .last_of_run_o (last_of_run_o)
  );

  assign phase_step_o = $signed(step_bits);

endmodule

// ===== rtl/peps_checker.sv =====
`include "polar_envelope_phase_shaper_core_defines.svh"

module peps_checker #(
  parameter int unsigned PWM_BITS = 10
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [PWM_BITS-1:0] pwm_level_o,
  input logic signed [23:0]  phase_step_o,
  input logic                gate_is_open_o,
  input logic                gate_changed_o,
  input logic                last_of_run_o
);

  // stalled word stays put
  `PEPS_ASSERT_STABLE(a_out_hold, out_valid_o && out_stall_i, {out_valid_o, pwm_level_o, phase_step_o, gate_is_open_o, gate_changed_o, last_of_run_o})

  // gate change flag only on the first word, never the last
  `PEPS_ASSERT(a_chg_first, out_valid_o && gate_changed_o |-> !last_of_run_o)

  // inside a run, step and gate state are constant
  `PEPS_ASSERT(a_run_const, out_valid_o && !out_stall_i && !last_of_run_o |=> !out_valid_o || ($stable(phase_step_o) && $stable(gate_is_open_o)))

  // no gate change flag after the first word of a run
  `PEPS_ASSERT(a_chg_mid, out_valid_o && !out_stall_i && !last_of_run_o |=> !out_valid_o || !gate_changed_o)

endmodule

bind polar_envelope_phase_shaper_core peps_checker #(
  .PWM_BITS(PWM_BITS)
) u_peps_checker (.*);
